### rtl/spuadpcm_pkg.sv
// Shared types, constants and coefficient tables of the ADPCM block decoder.
`default_nettype none
package spuadpcm_pkg;

  // Byte roles within a 16-byte block
  localparam logic [3:0] POS_HEADER = 4'd0;
  localparam logic [3:0] POS_FLAGS  = 4'd1;
  localparam logic [3:0] POS_LAST   = 4'd15;

  // Header remapping
  localparam logic [3:0] SHIFT_MAX   = 4'd12;
  localparam logic [3:0] SHIFT_SUBST = 4'd9;
  localparam logic [2:0] FILTER_MAX  = 3'd4;

  // Sample arithmetic
  localparam logic [3:0] SCALE_BASE = 4'd12;
  localparam int unsigned PRED_SHIFT = 6;

  // One data byte with the block context it needs
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] shift;
    logic [2:0] filter;
    logic [7:0] flags;
    logic       last;
  } cmd_t;

  // One decoded result
  typedef struct packed {
    logic signed [15:0] sample;
    logic [7:0]         flags;
    logic               last;
  } res_t;

  // Weight of the previous sample
  function automatic logic signed [7:0] coef_pos(input logic [2:0] f);
    case (f)
      3'd0:    coef_pos = 8'sd0;
      3'd1:    coef_pos = 8'sd60;
      3'd2:    coef_pos = 8'sd115;
      3'd3:    coef_pos = 8'sd98;
      default: coef_pos = 8'sd122;
    endcase
  endfunction

  // Weight of the sample before that
  function automatic logic signed [7:0] coef_neg(input logic [2:0] f);
    case (f)
      3'd0:    coef_neg = 8'sd0;
      3'd1:    coef_neg = 8'sd0;
      3'd2:    coef_neg = -8'sd52;
      3'd3:    coef_neg = -8'sd55;
      default: coef_neg = -8'sd60;
    endcase
  endfunction

endpackage
`default_nettype wire

### rtl/spu_adpcm_block_decoder.sv
// Top level of the ADPCM block decoder: front end, command queue, back end.
//
//   channel   direction  handshake              payload
//   in_       input      in_push / in_full      in_data_byte[7:0]
//   out_      output     out_pop / out_empty    out_sample, out_block_flags, out_last_of_block
//
// Header and flag bytes are accepted but give no sample.
// Each data byte gives two samples, one per cycle while the result queue has room, from
// the back end's single multiply-accumulate datapath.
// With the back end idle, a data byte's samples pass through the command queue, the
// command register and the result queue; a byte queued behind others also waits for them.
// Synchronous reset clears position, header context, history and both queues.
// in_full follows the two-entry command queue; a missing out_pop stalls the back end, then the input.
`default_nettype none
module spu_adpcm_block_decoder (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_push,
  input  wire  [7:0]          in_data_byte,
  output logic                in_full,
  input  wire                 out_pop,
  output logic                out_empty,
  output logic signed [15:0]  out_sample,
  output logic [7:0]          out_block_flags,
  output logic                out_last_of_block
);
  import spuadpcm_pkg::*;

  cmd_t fe_cmd, q_cmd;
  logic fe_push, q_full, q_valid, be_pop;

  spuadpcm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .in_full      (in_full),
    .cmdq_full    (q_full),
    .cmd_push     (fe_push),
    .cmd_out      (fe_cmd)
  );

  spuadpcm_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fe_push),
    .push_data (fe_cmd),
    .full      (q_full),
    .pop       (be_pop),
    .valid     (q_valid),
    .pop_data  (q_cmd)
  );

  spuadpcm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (q_valid),
    .cmd_in            (q_cmd),
    .cmd_pop           (be_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_sample        (out_sample),
    .out_block_flags   (out_block_flags),
    .out_last_of_block (out_last_of_block)
  );

endmodule
`default_nettype wire

### rtl/spuadpcm_front.sv
// Front end: tracks byte position, latches header and flags, forwards data bytes.
`default_nettype none
module spuadpcm_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_push,
  input  wire  [7:0]           in_data_byte,
  output logic                 in_full,
  input  wire                  cmdq_full,
  output logic                 cmd_push,
  output spuadpcm_pkg::cmd_t   cmd_out
);
  import spuadpcm_pkg::*;

  logic [3:0] pos_r, pos_nxt;
  logic [3:0] shift_r, shift_nxt;
  logic [2:0] filt_r, filt_nxt;
  logic [7:0] flags_r, flags_nxt;
  logic       accept;

  // Any byte waits while the queue is full
  assign in_full = cmdq_full;
  assign accept  = in_push && !cmdq_full;

  // Classify the byte and update block context
  always_comb begin
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    filt_nxt  = filt_r;
    flags_nxt = flags_r;
    cmd_push  = 1'b0;
    if (accept) begin
      pos_nxt = pos_r + 4'd1;
      if (pos_r == POS_HEADER) begin
        shift_nxt = (in_data_byte[3:0] > SHIFT_MAX) ? SHIFT_SUBST : in_data_byte[3:0];
        filt_nxt  = (in_data_byte[6:4] > FILTER_MAX) ? FILTER_MAX : in_data_byte[6:4];
      end else if (pos_r == POS_FLAGS) begin
        flags_nxt = in_data_byte;
      end else begin
        cmd_push = 1'b1;
      end
    end
  end

  assign cmd_out.data   = in_data_byte;
  assign cmd_out.shift  = shift_r;
  assign cmd_out.filter = filt_r;
  assign cmd_out.flags  = flags_r;
  assign cmd_out.last   = (pos_r == POS_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_HEADER;
      shift_r <= 4'd0;
      filt_r  <= 3'd0;
      flags_r <= 8'd0;
    end else begin
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      filt_r  <= filt_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/spuadpcm_cmdq.sv
// Two-entry queue of data-byte commands between front and back end.
`default_nettype none
module spuadpcm_cmdq (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  spuadpcm_pkg::cmd_t   push_data,
  output logic                 full,
  input  wire                  pop,
  output logic                 valid,
  output spuadpcm_pkg::cmd_t   pop_data
);
  import spuadpcm_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = mem_r[rd_ptr_r];

  // Occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

### rtl/spuadpcm_back.sv
// Back end: decodes two nibbles per command and queues the samples.
`default_nettype none
module spuadpcm_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cmd_valid,
  input  spuadpcm_pkg::cmd_t   cmd_in,
  output logic                 cmd_pop,
  input  wire                  out_pop,
  output logic                 out_empty,
  output logic signed [15:0]   out_sample,
  output logic [7:0]           out_block_flags,
  output logic                 out_last_of_block
);
  import spuadpcm_pkg::*;

  cmd_t               cmd_r;
  logic               busy_r, busy_nxt;
  logic               phase_r, phase_nxt;
  logic signed [15:0] prev_r, earl_r;
  res_t               oq_r [2];
  logic               oq_wr_r, oq_rd_r;
  logic [1:0]         oq_cnt_r, oq_cnt_nxt;
  logic               oq_full, oq_pop, produce;

  logic [3:0]         nib;
  logic [3:0]         sh_amt;
  logic [16:0]        scaled;
  logic signed [23:0] prod_a, prod_b;
  logic signed [24:0] acc;
  logic signed [18:0] pred;
  logic signed [19:0] sum;
  logic signed [15:0] sat;
  res_t               res;

  assign oq_full = (oq_cnt_r == 2'd2);
  assign oq_pop  = out_pop && !out_empty;
  assign produce = busy_r && !oq_full;
  assign cmd_pop = cmd_valid && (!busy_r || (phase_r && produce));

  // Sample arithmetic: scaled nibble plus rounded prediction, saturated
  always_comb begin
    nib    = phase_r ? cmd_r.data[7:4] : cmd_r.data[3:0];
    sh_amt = SCALE_BASE - cmd_r.shift;
    scaled = {{13{nib[3]}}, nib} << sh_amt;
    prod_a = prev_r * coef_pos(cmd_r.filter);
    prod_b = earl_r * coef_neg(cmd_r.filter);
    acc    = 25'(prod_a) + 25'(prod_b) + 25'sd32;
    pred   = acc[24:PRED_SHIFT];
    sum    = {{3{scaled[16]}}, scaled} + {pred[18], pred};
    if (sum > 20'sd32767)       sat = 16'sh7fff;
    else if (sum < -20'sd32768) sat = -16'sh8000;
    else                        sat = sum[15:0];
    res.sample = sat;
    res.flags  = cmd_r.flags;
    res.last   = cmd_r.last && phase_r;
  end

  // Command sequencing: low nibble then high nibble
  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    if (produce) phase_nxt = ~phase_r;
    if (produce && phase_r) busy_nxt = 1'b0;
    if (cmd_pop) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
    end
  end

  // Result queue occupancy
  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (produce && !oq_pop) oq_cnt_nxt = oq_cnt_r + 2'd1;
    else if (!produce && oq_pop) oq_cnt_nxt = oq_cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      phase_r  <= 1'b0;
      prev_r   <= 16'sd0;
      earl_r   <= 16'sd0;
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      busy_r   <= busy_nxt;
      phase_r  <= phase_nxt;
      oq_cnt_r <= oq_cnt_nxt;
      if (produce) begin
        prev_r  <= sat;
        earl_r  <= prev_r;
        oq_wr_r <= ~oq_wr_r;
      end
      if (oq_pop) oq_rd_r <= ~oq_rd_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_pop) cmd_r <= cmd_in;
    if (produce) oq_r[oq_wr_r] <= res;
  end

  assign out_empty         = (oq_cnt_r == 2'd0);
  assign out_sample        = oq_r[oq_rd_r].sample;
  assign out_block_flags   = oq_r[oq_rd_r].flags;
  assign out_last_of_block = oq_r[oq_rd_r].last;

endmodule
`default_nettype wire

### rtl/spuadpcm_checker.sv
// Port-level checks of the ADPCM block decoder and their bind.
`default_nettype none
module spuadpcm_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_push,
  input wire               in_full,
  input wire               out_pop,
  input wire               out_empty,
  input wire signed [15:0] out_sample,
  input wire  [7:0]        out_block_flags,
  input wire               out_last_of_block
);

  // Reset leaves both sides open and no result waiting
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not cleared by reset");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_sample)
      && $stable(out_block_flags) && $stable(out_last_of_block)))
    else $error("waiting result changed before pop");

  // No result is waiting yet in the cycle after the first cycle out of an idle reset state
  a_no_early: assert property (@(posedge clk)
    ($past(!rst_n) && rst_n) |=> out_empty)
    else $error("result appeared too soon after reset");

  // The item after a block's last sample is a low nibble, never marked last
  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && out_last_of_block && !in_push)
      |=> !(!out_empty && out_last_of_block))
    else $error("two last-of-block samples in a row");

endmodule

bind spu_adpcm_block_decoder spuadpcm_checker u_spuadpcm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_push           (in_push),
  .in_full           (in_full),
  .out_pop           (out_pop),
  .out_empty         (out_empty),
  .out_sample        (out_sample),
  .out_block_flags   (out_block_flags),
  .out_last_of_block (out_last_of_block)
);
`default_nettype wire

### tb/tb_spu_adpcm_block_decoder.sv
`timescale 1ns / 100ps
// Testbench for the ADPCM block decoder: directed byte table, then random blocks checked by a predictor.
module tb_spu_adpcm_block_decoder;
  import spuadpcm_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int TIMEOUT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES   = 10;
  localparam int RANDOM_BYTES    = 750;
  localparam int HOLD_OFF_AT     = 150;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MID_DRAIN_AT    = 400;
  localparam int MAX_REPORTS     = 100;
  localparam int DIRECTED_ROWS   = 22;

  // Filter weights for the two history samples
  localparam int PREV_WEIGHT [5]    = '{0, 60, 115, 98, 122};
  localparam int EARLIER_WEIGHT [5] = '{0, 0, -52, -55, -60};

  // Nibbles that keep the history quiet
  localparam logic [3:0] QUIET_NIBS [4] = '{4'h0, 4'h1, 4'hF, 4'hE};

  // One row of the directed table; samples are typed only where typed is set
  typedef struct {
    logic [7:0]         data;
    bit                 typed;
    logic signed [15:0] s_lo;
    logic signed [15:0] s_hi;
    logic [7:0]         flags;
    logic               last;
  } byte_row_t;

  // Block 1: bit 7 set, shift 13 remapped to 9, filter 0, so every sample is nibble * 8.
  // Block 2: bit 7 set, filter 7 clamped to 4, shift 0, so the history saturates.
  byte_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h8D, 1'b0, 16'sd0,   16'sd0,   8'h00, 1'b0},
    '{8'hA5, 1'b0, 16'sd0,   16'sd0,   8'h00, 1'b0},
    '{8'h77, 1'b1, 16'sd56,  16'sd56,  8'hA5, 1'b0},
    '{8'h88, 1'b1, -16'sd64, -16'sd64, 8'hA5, 1'b0},
    '{8'hF1, 1'b1, 16'sd8,   -16'sd8,  8'hA5, 1'b0},
    '{8'h00, 1'b1, 16'sd0,   16'sd0,   8'hA5, 1'b0},
    '{8'h8F, 1'b1, -16'sd8,  -16'sd64, 8'hA5, 1'b0},
    '{8'h7E, 1'b1, -16'sd16, 16'sd56,  8'hA5, 1'b0},
    '{8'h12, 1'b1, 16'sd16,  16'sd8,   8'hA5, 1'b0},
    '{8'h34, 1'b1, 16'sd32,  16'sd24,  8'hA5, 1'b0},
    '{8'h56, 1'b1, 16'sd48,  16'sd40,  8'hA5, 1'b0},
    '{8'h9A, 1'b1, -16'sd48, -16'sd56, 8'hA5, 1'b0},
    '{8'hBC, 1'b1, -16'sd32, -16'sd40, 8'hA5, 1'b0},
    '{8'hDE, 1'b1, -16'sd16, -16'sd24, 8'hA5, 1'b0},
    '{8'h01, 1'b1, 16'sd8,   16'sd0,   8'hA5, 1'b0},
    '{8'h10, 1'b1, 16'sd0,   16'sd8,   8'hA5, 1'b1},
    '{8'hF0, 1'b0, 16'sd0,   16'sd0,   8'h00, 1'b0},
    '{8'h5A, 1'b0, 16'sd0,   16'sd0,   8'h00, 1'b0},
    '{8'h77, 1'b0, 16'sd0,   16'sd0,   8'h00, 1'b0},
    '{8'h88, 1'b0, 16'sd0,   16'sd0,   8'h00, 1'b0},
    '{8'h80, 1'b0, 16'sd0,   16'sd0,   8'h00, 1'b0},
    '{8'h99, 1'b0, 16'sd0,   16'sd0,   8'h00, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic [7:0]         in_data_byte = 8'h00;
  logic               in_full;
  logic               out_pop = 1'b0;
  logic               out_empty;
  logic signed [15:0] out_sample;
  logic [7:0]         out_block_flags;
  logic               out_last_of_block;

  // Predictor state, reset values
  logic [3:0]         dec_pos = POS_HEADER;
  logic [3:0]         dec_shift = 4'd0;
  logic [2:0]         dec_filter = 3'd0;
  logic [7:0]         dec_flags = 8'h00;
  logic signed [15:0] hist_prev = 16'sd0;
  logic signed [15:0] hist_earlier = 16'sd0;

  res_t expected_samples [$];
  res_t next_sample;
  int   error_count = 0;
  int   cycle_count = 0;
  int   tx_pos = 0;
  bit   tx_burst = 1'b0;
  logic hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;
  int   rx_wait = 0;
  int   rx_cycles = 0;
  logic [7:0] rand_data;

  spu_adpcm_block_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_data_byte     (in_data_byte),
    .in_full          (in_full),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_sample       (out_sample),
    .out_block_flags  (out_block_flags),
    .out_last_of_block(out_last_of_block)
  );

  always #CLK_HALF clk = ~clk;

  // One nibble through scale, prediction and saturation; updates the history
  function automatic logic signed [15:0] decode_nibble(input logic [3:0] nib);
    int scaled;
    int guess;
    int total;
    scaled = int'($signed(nib)) * (1 << (int'(SCALE_BASE) - int'(dec_shift)));
    guess = (int'(hist_prev) * PREV_WEIGHT[dec_filter]
             + int'(hist_earlier) * EARLIER_WEIGHT[dec_filter] + 32) >>> PRED_SHIFT;
    total = scaled + guess;
    if (total > 32767) total = 32767;
    if (total < -32768) total = -32768;
    hist_earlier = hist_prev;
    hist_prev = total[15:0];
    return total[15:0];
  endfunction

  // Consume one byte; returns how many samples it yields
  function automatic int predict_byte(input logic [7:0] b, output res_t lo, output res_t hi);
    logic [3:0] pos;
    pos = dec_pos;
    dec_pos = dec_pos + 4'd1;
    lo = '0;
    hi = '0;
    if (pos == POS_HEADER) begin
      dec_shift = (b[3:0] > SHIFT_MAX) ? SHIFT_SUBST : b[3:0];
      dec_filter = (b[6:4] > FILTER_MAX) ? FILTER_MAX : b[6:4];
      return 0;
    end
    if (pos == POS_FLAGS) begin
      dec_flags = b;
      return 0;
    end
    lo.sample = decode_nibble(b[3:0]);
    lo.flags = dec_flags;
    lo.last = 1'b0;
    hi.sample = decode_nibble(b[7:4]);
    hi.flags = dec_flags;
    hi.last = (pos == POS_LAST);
    return 2;
  endfunction

  // Sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_burst || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver stall, same shape
  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Random byte shaped by its role in the block
  function automatic logic [7:0] random_byte();
    if (tx_pos == POS_HEADER || tx_pos == POS_FLAGS) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0, 1:    return 8'($urandom_range(0, 255));
      2:       return {QUIET_NIBS[$urandom_range(0, 3)], QUIET_NIBS[$urandom_range(0, 3)]};
      default: return {($urandom_range(0, 1) ? 4'h7 : 4'h8), ($urandom_range(0, 1) ? 4'h7 : 4'h8)};
    endcase
  endfunction

  // Offer one item, wait for it to be taken, then queue what it should give
  task automatic send_byte(input logic [7:0] b, input bit typed, input res_t t_lo,
                           input res_t t_hi, input int gap);
    res_t p_lo;
    res_t p_hi;
    int n;
    in_push <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_full);
    tx_pos = (tx_pos + 1) % 16;
    n = predict_byte(b, p_lo, p_hi);
    if (n > 0) begin
      expected_samples.push_back(typed ? t_lo : p_lo);
      expected_samples.push_back(typed ? t_hi : p_hi);
    end
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every expected sample is out and the pipe has settled
  task automatic drain_results();
    in_push <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_field(input string field, input int exp_v, input int act_v);
    error_count++;
    if (error_count <= MAX_REPORTS) $error("%s: expected %0d, got %0d", field, exp_v, act_v);
  endtask

  // Stimulus
  initial begin
    res_t t_lo;
    res_t t_hi;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      t_lo = '{sample: directed_rows[i].s_lo, flags: directed_rows[i].flags, last: 1'b0};
      t_hi = '{sample: directed_rows[i].s_hi, flags: directed_rows[i].flags,
               last: directed_rows[i].last};
      send_byte(directed_rows[i].data, directed_rows[i].typed, t_lo, t_hi, pick_gap());
    end
    drain_results();

    for (int i = 0; i < RANDOM_BYTES; i++) begin
      // burst stretches, one of them over the receiver hold-off
      tx_burst = ((i / 60) % 4 == 0) || (i >= HOLD_OFF_AT && i < HOLD_OFF_AT + 50);
      if (i == HOLD_OFF_AT) hold_req <= 1'b1;
      if (i == MID_DRAIN_AT) drain_results();
      rand_data = random_byte();
      send_byte(rand_data, 1'b0, '0, '0, pick_gap());
    end
    in_push <= 1'b0;

    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver: random stalls, calm stretches, one long hold-off
  always @(posedge clk) begin
    rx_cycles++;
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      rx_wait = ((rx_cycles / 1500) % 4 == 1) ? 0 : pick_stall();
    end
  end

  // Compare each accepted sample with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_samples.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $error("sample: expected none, got %0d", out_sample);
      end else begin
        next_sample = expected_samples.pop_front();
        if (out_sample !== next_sample.sample)
          report_field("sample", next_sample.sample, out_sample);
        if (out_block_flags !== next_sample.flags)
          report_field("block_flags", next_sample.flags, out_block_flags);
        if (out_last_of_block !== next_sample.last)
          report_field("last_of_block", next_sample.last, out_last_of_block);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
